// File: src/fgq_pkg.sv
// Shared types and constants for the friend graph query engine.
package fgq_pkg;

  localparam logic [1:0] OP_ADD_USER   = 2'd0;
  localparam logic [1:0] OP_ADD_FRIEND = 2'd1;
  localparam logic [1:0] OP_COMMON     = 2'd2;
  localparam logic [1:0] OP_DISTANCE   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_LIST_FULL  = 2'd2;

  localparam int MAX_RESULTS = 64;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] id_a;
    logic [9:0] id_b;
    logic [5:0] hop_count;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       has_user;
    logic [9:0] user_id;
    logic       last;
  } out_t;

endpackage

// File: src/friend_graph_query_engine_top.sv
// Top level of the friend graph query engine: sequencer around the graph memories.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------
//  input   | in        | in_valid_i / in_stall_o | in_i  (opcode, ids, hops)
//  output  | out       | out_valid_o/ out_stall_i| out_o (status, id, last)
//
// One item is processed at a time. A user lookup scans the id memory one
// stored user at a time, reading and then comparing; common friends compares
// every pair of list entries; the depth-first walk reads the list length,
// checks and follows each list entry examined, pops exhausted entries off the
// stack and reads the id of every reported user. Reset clears the user count,
// visited marks, sequencer state, result count and output valid flags; the
// memories need no clearing. A stalled output delays the sequencer whenever a
// result has to move into a still occupied output register: when a second
// result is ready, since one result is held back to mark the last, and when
// the final result is released.
module friend_graph_query_engine_top #(
  parameter int USER_SLOTS   = 32,
  parameter int FRIEND_SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fgq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fgq_pkg::out_t out_o
);

  localparam int SW = $clog2(USER_SLOTS);
  localparam int CW = $clog2(USER_SLOTS + 1);
  localparam int IW = $clog2(FRIEND_SLOTS + 1);
  localparam int AW = $clog2(USER_SLOTS * FRIEND_SLOTS);
  localparam int NW = $clog2(fgq_pkg::MAX_RESULTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_FOUND, S_TOT_A, S_TOT_B, S_TOT_C,
    S_ADD_A, S_ADD_B, S_CF_I, S_CF_IF, S_CF_J, S_CF_JF, S_UID_RD, S_UID_EM,
    S_WK_TOT, S_WK_CHK, S_WK_POP, S_WK_NXT, S_EMIT, S_FINISH
  } state_e;

  state_e        state_q, ret_q, back_q;
  fgq_pkg::in_t  req_q;
  logic [CW-1:0] total_q, scan_q;
  logic [9:0]    cur_id_q;
  logic          second_q;
  logic [SW-1:0] slot_a_q, slot_b_q, nxt_q, top_s_q;
  logic [IW-1:0] ta_q, tb_q, ci_q, cj_q, top_idx_q;
  logic [SW-1:0] fa_q;
  logic [CW-1:0] sp_q;
  logic [USER_SLOTS-1:0] vis_q;
  logic          found_q;
  logic [NW-1:0] n_q;
  fgq_pkg::out_t em_q, pend_q, out_q;
  logic          pend_v_q, out_valid_q;

  // Memory ports.
  logic          uid_we, tot_we, fsl_we, stk_we;
  logic [SW-1:0] uid_waddr, uid_raddr, tot_waddr, tot_raddr, stk_waddr, stk_raddr;
  logic [9:0]    uid_wdata, uid_rdata;
  logic [IW-1:0] tot_wdata, tot_rdata;
  logic [AW-1:0] fsl_waddr, fsl_raddr;
  logic [SW-1:0] fsl_wdata, fsl_rdata;
  logic [SW+IW-1:0] stk_wdata, stk_rdata;

  logic          out_free;
  logic          out_load;
  logic          room;
  logic [IW-1:0] tb_next;

  function automatic logic [AW-1:0] fsl_addr(input logic [SW-1:0] s,
                                             input logic [IW-1:0] k);
    return AW'(s) * AW'(FRIEND_SLOTS) + AW'(k);
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The output register takes a new item when the held result moves out.
  assign out_load = out_free && ((state_q == S_FINISH) ||
                    (state_q == S_EMIT && pend_v_q &&
                     32'(n_q) < fgq_pkg::MAX_RESULTS));

  // Room check for a new friendship; a self friendship needs two entries.
  always_comb begin
    if (slot_a_q == slot_b_q) begin
      room = ((IW + 1)'(ta_q) + (IW + 1)'(2)) <= (IW + 1)'(FRIEND_SLOTS);
    end else begin
      room = (32'(ta_q) < FRIEND_SLOTS) && (32'(tot_rdata) < FRIEND_SLOTS);
    end
  end

  assign tb_next = (slot_a_q == slot_b_q) ? IW'(ta_q + IW'(1)) : tb_q;

  // Memory addressing follows the current sequencer step.
  always_comb begin
    uid_we    = 1'b0;
    uid_waddr = SW'(total_q);
    uid_wdata = cur_id_q;
    uid_raddr = SW'(scan_q);
    tot_we    = 1'b0;
    tot_waddr = SW'(total_q);
    tot_wdata = '0;
    tot_raddr = top_s_q;
    fsl_we    = 1'b0;
    fsl_waddr = fsl_addr(slot_a_q, ta_q);
    fsl_wdata = slot_b_q;
    fsl_raddr = fsl_addr(top_s_q, top_idx_q);
    stk_we    = 1'b0;
    stk_waddr = SW'(sp_q - CW'(1));
    stk_wdata = {top_s_q, top_idx_q};
    stk_raddr = SW'(sp_q - CW'(2));
    unique case (state_q)
      S_FIND_RD: begin
        if (scan_q >= total_q && 32'(total_q) < USER_SLOTS) begin
          uid_we = 1'b1;
          tot_we = 1'b1;
        end
      end
      S_TOT_A: tot_raddr = slot_a_q;
      S_TOT_B: tot_raddr = slot_b_q;
      S_ADD_A: begin
        fsl_we    = 1'b1;
        tot_we    = 1'b1;
        tot_waddr = slot_a_q;
        tot_wdata = IW'(ta_q + IW'(1));
      end
      S_ADD_B: begin
        fsl_we    = 1'b1;
        fsl_waddr = fsl_addr(slot_b_q, tb_next);
        fsl_wdata = slot_a_q;
        tot_we    = 1'b1;
        tot_waddr = slot_b_q;
        tot_wdata = IW'(tb_next + IW'(1));
      end
      S_CF_I:   fsl_raddr = fsl_addr(slot_a_q, ci_q);
      S_CF_J:   fsl_raddr = fsl_addr(slot_b_q, cj_q);
      S_UID_RD: uid_raddr = nxt_q;
      S_WK_NXT: begin
        if (!vis_q[fsl_rdata] && 32'(sp_q) != 32'(req_q.hop_count)
            && 32'(sp_q) < USER_SLOTS) begin
          stk_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      vis_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      found_q     <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q    <= in_i;
            cur_id_q <= in_i.id_a;
            scan_q   <= '0;
            second_q <= 1'b0;
            n_q      <= '0;
            found_q  <= 1'b0;
            if (in_i.opcode == fgq_pkg::OP_DISTANCE) begin
              vis_q <= '0;
            end
            state_q <= S_FIND_RD;
          end
        end
        S_FIND_RD: begin
          if (scan_q < total_q) begin
            state_q <= S_FIND_CMP;
          end else if (32'(total_q) >= USER_SLOTS) begin
            em_q    <= '{status: fgq_pkg::ST_TABLE_FULL, has_user: 1'b0,
                         user_id: '0, last: 1'b0};
            ret_q   <= S_FINISH;
            state_q <= S_EMIT;
          end else begin
            nxt_q   <= SW'(total_q);
            total_q <= total_q + CW'(1);
            state_q <= S_FOUND;
          end
        end
        S_FIND_CMP: begin
          if (uid_rdata == cur_id_q) begin
            nxt_q   <= SW'(scan_q);
            state_q <= S_FOUND;
          end else begin
            scan_q  <= scan_q + CW'(1);
            state_q <= S_FIND_RD;
          end
        end
        S_FOUND: begin
          if (second_q) begin
            slot_b_q <= nxt_q;
            state_q  <= S_TOT_A;
          end else begin
            slot_a_q <= nxt_q;
            if (req_q.opcode == fgq_pkg::OP_ADD_USER) begin
              em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b0,
                           user_id: '0, last: 1'b0};
              ret_q   <= S_FINISH;
              state_q <= S_EMIT;
            end else if (req_q.opcode == fgq_pkg::OP_DISTANCE) begin
              vis_q[nxt_q] <= 1'b1;
              if (req_q.hop_count == '0) begin
                em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b1,
                             user_id: req_q.id_a, last: 1'b0};
                ret_q   <= S_FINISH;
                state_q <= S_EMIT;
              end else begin
                top_s_q   <= nxt_q;
                top_idx_q <= '0;
                sp_q      <= CW'(1);
                state_q   <= S_WK_TOT;
              end
            end else begin
              second_q <= 1'b1;
              cur_id_q <= req_q.id_b;
              scan_q   <= '0;
              state_q  <= S_FIND_RD;
            end
          end
        end
        S_TOT_A: state_q <= S_TOT_B;
        S_TOT_B: begin
          ta_q    <= tot_rdata;
          state_q <= S_TOT_C;
        end
        S_TOT_C: begin
          tb_q <= tot_rdata;
          if (req_q.opcode == fgq_pkg::OP_ADD_FRIEND) begin
            if (room) begin
              state_q <= S_ADD_A;
            end else begin
              em_q    <= '{status: fgq_pkg::ST_LIST_FULL, has_user: 1'b0,
                           user_id: '0, last: 1'b0};
              ret_q   <= S_FINISH;
              state_q <= S_EMIT;
            end
          end else begin
            ci_q    <= '0;
            state_q <= S_CF_I;
          end
        end
        S_ADD_A: state_q <= S_ADD_B;
        S_ADD_B: begin
          em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b0,
                       user_id: '0, last: 1'b0};
          ret_q   <= S_FINISH;
          state_q <= S_EMIT;
        end
        S_CF_I: begin
          if (ci_q < ta_q) begin
            state_q <= S_CF_IF;
          end else if (found_q) begin
            state_q <= S_FINISH;
          end else begin
            em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b0,
                         user_id: '0, last: 1'b0};
            ret_q   <= S_FINISH;
            state_q <= S_EMIT;
          end
        end
        S_CF_IF: begin
          fa_q    <= fsl_rdata;
          cj_q    <= '0;
          state_q <= S_CF_J;
        end
        S_CF_J: begin
          if (cj_q < tb_q) begin
            state_q <= S_CF_JF;
          end else begin
            ci_q    <= ci_q + IW'(1);
            state_q <= S_CF_I;
          end
        end
        S_CF_JF: begin
          cj_q <= cj_q + IW'(1);
          if (fsl_rdata == fa_q) begin
            nxt_q   <= fsl_rdata;
            back_q  <= S_CF_J;
            state_q <= S_UID_RD;
          end else begin
            state_q <= S_CF_J;
          end
        end
        S_UID_RD: state_q <= S_UID_EM;
        S_UID_EM: begin
          found_q <= 1'b1;
          em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b1,
                       user_id: uid_rdata, last: 1'b0};
          ret_q   <= back_q;
          state_q <= S_EMIT;
        end
        S_WK_TOT: state_q <= S_WK_CHK;
        S_WK_CHK: begin
          if (top_idx_q >= tot_rdata || 32'(top_idx_q) >= FRIEND_SLOTS) begin
            // Entry exhausted: pop it, or end the walk at the bottom.
            sp_q <= sp_q - CW'(1);
            if (sp_q == CW'(1)) begin
              if (found_q) begin
                state_q <= S_FINISH;
              end else begin
                em_q    <= '{status: fgq_pkg::ST_OK, has_user: 1'b0,
                             user_id: '0, last: 1'b0};
                ret_q   <= S_FINISH;
                state_q <= S_EMIT;
              end
            end else begin
              state_q <= S_WK_POP;
            end
          end else begin
            top_idx_q <= top_idx_q + IW'(1);
            state_q   <= S_WK_NXT;
          end
        end
        S_WK_POP: begin
          top_s_q   <= stk_rdata[SW+IW-1:IW];
          top_idx_q <= stk_rdata[IW-1:0];
          state_q   <= S_WK_TOT;
        end
        S_WK_NXT: begin
          if (vis_q[fsl_rdata]) begin
            state_q <= S_WK_TOT;
          end else begin
            vis_q[fsl_rdata] <= 1'b1;
            if (32'(sp_q) == 32'(req_q.hop_count)) begin
              nxt_q   <= fsl_rdata;
              back_q  <= S_WK_TOT;
              state_q <= S_UID_RD;
            end else begin
              if (32'(sp_q) < USER_SLOTS) begin
                top_s_q   <= fsl_rdata;
                top_idx_q <= '0;
                sp_q      <= sp_q + CW'(1);
              end
              state_q <= S_WK_TOT;
            end
          end
        end
        S_EMIT: begin
          // One result is always held back so the final one can carry last.
          if (32'(n_q) >= fgq_pkg::MAX_RESULTS) begin
            state_q <= ret_q;
          end else if (!pend_v_q) begin
            pend_q   <= em_q;
            pend_v_q <= 1'b1;
            n_q      <= n_q + NW'(1);
            state_q  <= ret_q;
          end else if (out_free) begin
            out_q   <= pend_q;
            pend_q  <= em_q;
            n_q     <= n_q + NW'(1);
            state_q <= ret_q;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_q    <= '{status: pend_q.status, has_user: pend_q.has_user,
                          user_id: pend_q.user_id, last: 1'b1};
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  fgq_ram #(.WIDTH(10), .DEPTH(USER_SLOTS)) u_uid (
    .clk_i, .we_i(uid_we), .waddr_i(uid_waddr), .wdata_i(uid_wdata),
    .raddr_i(uid_raddr), .rdata_o(uid_rdata)
  );

  fgq_ram #(.WIDTH(IW), .DEPTH(USER_SLOTS)) u_tot (
    .clk_i, .we_i(tot_we), .waddr_i(tot_waddr), .wdata_i(tot_wdata),
    .raddr_i(tot_raddr), .rdata_o(tot_rdata)
  );

  fgq_ram #(.WIDTH(SW), .DEPTH(USER_SLOTS * FRIEND_SLOTS)) u_fsl (
    .clk_i, .we_i(fsl_we), .waddr_i(fsl_waddr), .wdata_i(fsl_wdata),
    .raddr_i(fsl_raddr), .rdata_o(fsl_rdata)
  );

  fgq_ram #(.WIDTH(SW + IW), .DEPTH(USER_SLOTS)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

endmodule

// File: src/fgq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: dv/tb_top.sv
// Testbench for the friend graph query engine: random and directed graph operations.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USERS   = 32;
  localparam int FRIENDS = 8;
  localparam int STALL_LIMIT = 200000;

  // Graph model and result checker. It holds its own copy of the user table
  // and friend lists and computes the result items of every accepted query.
  class graph_scoreboard;
    logic [9:0]    ids [USERS];
    int            n_users;
    int            n_friends [USERS];
    int            links [USERS][FRIENDS];
    bit            seen [USERS];
    int            stack_slot [USERS];
    int            stack_pos [USERS];
    fgq_pkg::out_t pending [$];
    int            mismatches;
    int            results_seen;

    function new();
      n_users = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void push(logic [1:0] st, bit has, logic [9:0] id);
      fgq_pkg::out_t r;
      r.status = st;
      r.has_user = has;
      r.user_id = has ? id : 10'd0;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    // Finds the slot of an id, creating the user when absent. Returns -1 on a full table.
    function int lookup(logic [9:0] id);
      for (int i = 0; i < n_users; i++)
        if (ids[i] == id) return i;
      if (n_users >= USERS) return -1;
      ids[n_users] = id;
      n_friends[n_users] = 0;
      n_users++;
      return n_users - 1;
    endfunction

    // Depth-first walk; users entered at exactly the target depth are reported.
    function int walk(int start, int target, int budget);
      int sp, s, k, nxt, cnt;
      cnt = 0;
      for (int i = 0; i < USERS; i++) seen[i] = 0;
      seen[start] = 1;
      if (target == 0) begin
        push(fgq_pkg::ST_OK, 1, ids[start]);
        return 1;
      end
      stack_slot[0] = start;
      stack_pos[0] = 0;
      sp = 1;
      while (sp > 0) begin
        s = stack_slot[sp-1];
        k = stack_pos[sp-1];
        if (k >= n_friends[s]) begin
          sp--;
          continue;
        end
        stack_pos[sp-1] = k + 1;
        nxt = links[s][k];
        if (seen[nxt]) continue;
        seen[nxt] = 1;
        if (sp == target) begin
          if (cnt < budget) begin
            push(fgq_pkg::ST_OK, 1, ids[nxt]);
            cnt++;
          end
        end else if (sp < USERS) begin
          stack_slot[sp] = nxt;
          stack_pos[sp] = 0;
          sp++;
        end
      end
      return cnt;
    endfunction

    // Notes an accepted input item and queues the result items it causes.
    function void note_query(fgq_pkg::in_t q);
      int sa, sb, base, cnt;
      bit room;
      fgq_pkg::out_t tail;
      base = pending.size();
      cnt = 0;
      sa = lookup(q.id_a);
      if (sa < 0) begin
        push(fgq_pkg::ST_TABLE_FULL, 0, 0);
      end else if (q.opcode == fgq_pkg::OP_ADD_USER) begin
        push(fgq_pkg::ST_OK, 0, 0);
      end else if (q.opcode == fgq_pkg::OP_DISTANCE) begin
        if (walk(sa, q.hop_count, fgq_pkg::MAX_RESULTS) == 0) push(fgq_pkg::ST_OK, 0, 0);
      end else begin
        sb = lookup(q.id_b);
        if (sb < 0) begin
          push(fgq_pkg::ST_TABLE_FULL, 0, 0);
        end else if (q.opcode == fgq_pkg::OP_ADD_FRIEND) begin
          if (sa == sb) room = n_friends[sa] + 2 <= FRIENDS;
          else room = n_friends[sa] < FRIENDS && n_friends[sb] < FRIENDS;
          if (room) begin
            links[sa][n_friends[sa]] = sb;
            n_friends[sa] = n_friends[sa] + 1;
            links[sb][n_friends[sb]] = sa;
            n_friends[sb] = n_friends[sb] + 1;
            push(fgq_pkg::ST_OK, 0, 0);
          end else begin
            push(fgq_pkg::ST_LIST_FULL, 0, 0);
          end
        end else begin
          for (int i = 0; i < n_friends[sa]; i++)
            for (int j = 0; j < n_friends[sb]; j++)
              if (links[sa][i] == links[sb][j] && cnt < fgq_pkg::MAX_RESULTS) begin
                push(fgq_pkg::ST_OK, 1, ids[links[sb][j]]);
                cnt++;
              end
          if (cnt == 0) push(fgq_pkg::ST_OK, 0, 0);
        end
      end
      tail = pending[pending.size()-1];
      tail.last = 1'b1;
      pending[pending.size()-1] = tail;
    endfunction

    // Checks one accepted result item against the oldest expected one.
    function void check_result(fgq_pkg::out_t got);
      fgq_pkg::out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.has_user !== want.has_user ||
          got.user_id !== want.user_id || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  fgq_pkg::in_t  in_item;
  fgq_pkg::out_t out_item;

  graph_scoreboard sb = new();

  // Idle rates in percent; the phases below change them.
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  friend_graph_query_engine_top #(.USER_SLOTS(USERS), .FRIEND_SLOTS(FRIENDS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_item)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Accepted items are sampled at the rising edge, before the drivers'
  // nonblocking updates land, so the view never depends on event order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_query(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b1;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one item and holds it until it is accepted. The valid stays high
  // into the next item when no idle cycle is drawn.
  task automatic send_query(logic [1:0] op, logic [9:0] a, logic [9:0] b, logic [5:0] h);
    fgq_pkg::in_t q;
    q.opcode = op;
    q.id_a = a;
    q.id_b = b;
    q.hop_count = h;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= q;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Ids come mostly from a small pool so the graph gets dense and queries hit.
  function automatic logic [9:0] pick_id(int pool_base);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 10'd1023;
    if (r < 6) return 10'd0;
    if (r < 12) return 10'($urandom_range(1023));
    return 10'(pool_base + $urandom_range(11));
  endfunction

  task automatic random_part(int count, int pool_base);
    int r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      op = r < 10 ? fgq_pkg::OP_ADD_USER : r < 50 ? fgq_pkg::OP_ADD_FRIEND :
           r < 72 ? fgq_pkg::OP_COMMON : fgq_pkg::OP_DISTANCE;
      send_query(op, pick_id(pool_base), pick_id(pool_base),
                 $urandom_range(99) < 85 ? 6'($urandom_range(4)) : 6'($urandom_range(63)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation, self friendship, list full, no match,
    // depth zero, extremes of every field.
    send_query(fgq_pkg::OP_ADD_USER, 10'd0, 10'd1023, 6'd63);
    send_query(fgq_pkg::OP_ADD_USER, 10'd0, 10'd0, 6'd0);
    send_query(fgq_pkg::OP_ADD_FRIEND, 10'd1023, 10'd1000, 6'd0);
    send_query(fgq_pkg::OP_ADD_FRIEND, 10'd0, 10'd1023, 6'd0);
    send_query(fgq_pkg::OP_COMMON, 10'd0, 10'd1000, 6'd0);
    send_query(fgq_pkg::OP_COMMON, 10'd0, 10'd0, 6'd0);
    send_query(fgq_pkg::OP_DISTANCE, 10'd0, 10'd0, 6'd0);
    send_query(fgq_pkg::OP_DISTANCE, 10'd0, 10'd0, 6'd2);
    send_query(fgq_pkg::OP_DISTANCE, 10'd0, 10'd0, 6'd63);
    send_query(fgq_pkg::OP_ADD_FRIEND, 10'd5, 10'd5, 6'd0);
    send_query(fgq_pkg::OP_COMMON, 10'd5, 10'd5, 6'd0);
    for (int i = 0; i < 4; i++) send_query(fgq_pkg::OP_ADD_FRIEND, 10'd7, 10'd7, 6'd0);
    for (int i = 0; i < 8; i++) send_query(fgq_pkg::OP_ADD_FRIEND, 10'd9, 10'(10 + i), 6'd0);
    send_query(fgq_pkg::OP_ADD_FRIEND, 10'd9, 10'd999, 6'd0);
    release_input();
    wait_drained();

    // Long receiver hold-off while items keep coming, then a drained pause.
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      random_part(20, 100);
    join
    release_input();
    wait_drained();

    send_idle = 6; recv_idle = 53;
    random_part(90, 100);
    send_idle = 53; recv_idle = 6;
    random_part(90, 200);
    send_idle = 0; recv_idle = 0;
    random_part(60, 300);
    // Fill the table to exercise the full-table status.
    for (int i = 0; i < 40; i++)
      send_query(fgq_pkg::OP_ADD_FRIEND, 10'(500 + i), 10'(600 + i), 6'd1);
    release_input();
    wait_drained();
    repeat (200) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: friend_graph_query_engine_top.f
src/fgq_pkg.sv
src/fgq_ram.sv
src/friend_graph_query_engine_top.sv
dv/tb_top.sv
